// File: sv/i2cssd_pkg.sv
// Package: shared types, command codes and the segment pattern table.
`timescale 1ns / 1ps
package i2cssd_pkg;

   // Event codes on the request channel
   localparam logic [1:0] CMD_BYTE   = 2'd0;
   localparam logic [1:0] CMD_STOP   = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_COLON_BLINK_EN = 2'd0;
   localparam logic [1:0] CSR_BLINK_FRAMES   = 2'd1;
   localparam logic [1:0] CSR_STARTUP_TICKS  = 2'd2;

   localparam int unsigned CSR_DATA_WIDTH = 9;

   // Configuration reset values
   localparam logic [7:0] BLINK_FRAMES_RESET  = 8'd50;
   localparam logic [8:0] STARTUP_TICKS_RESET = 9'd300;

   // Default last receive buffer index
   localparam int unsigned LAST_RX_INDEX_DEFAULT = 5;

   // Digit codes
   localparam logic [3:0] BLANK_CODE = 4'd10;
   localparam logic [3:0] EIGHT_CODE = 4'd8;
   localparam logic [3:0] ZERO_CODE  = 4'd0;

   // Front-to-back queue depth
   localparam int unsigned QUEUE_DEPTH = 2;

   // Operation kinds carried through the queue
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_STOP = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;
   localparam logic [1:0] KIND_NOP  = 2'd3;

   typedef logic [3:0][3:0] codes_type;

   // One classified event, front to back
   typedef struct packed {
      logic [1:0] kind;
      logic       ack;
      logic       update;
      codes_type  codes;
   } op_type;

   // Segment pattern per digit code; codes ten and above show the blank pattern
   function automatic logic [7:0] seg_pattern(input logic [3:0] code);
      logic [7:0] pat;
      unique case (code)
         4'd0:    pat = 8'h7F;
         4'd1:    pat = 8'h0E;
         4'd2:    pat = 8'hB7;
         4'd3:    pat = 8'h9F;
         4'd4:    pat = 8'hCE;
         4'd5:    pat = 8'hDD;
         4'd6:    pat = 8'hFD;
         4'd7:    pat = 8'h0F;
         4'd8:    pat = 8'hFF;
         4'd9:    pat = 8'hDF;
         default: pat = 8'h04;
      endcase
      return pat;
   endfunction

endpackage

// File: sv/i2cssd_front.sv
// Front end: receive buffer, ACK generation and command decode at stop.
`timescale 1ns / 1ps
module i2cssd_front #(
   parameter int unsigned LAST_RX_INDEX = i2cssd_pkg::LAST_RX_INDEX_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_command,
   input  logic [7:0]          in_rx_byte,
   output logic                push,
   output i2cssd_pkg::op_type  push_op,
   input  logic                queue_full
);
   import i2cssd_pkg::*;

   localparam int unsigned DEPTH   = LAST_RX_INDEX + 1;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned IDX_W   = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LAST_RX_INDEX);

   // Value / 10 for values up to 99 (reciprocal multiply)
   function automatic logic [3:0] tens_of(input logic [7:0] v);
      logic [15:0] p;
      p = {8'd0, v} * 16'd205;
      return p[14:11];
   endfunction

   // Value % 10 for values up to 99
   function automatic logic [3:0] ones_of(input logic [7:0] v);
      logic [7:0] t;
      t = v - ({4'd0, tens_of(v)} * 8'd10);
      return t[3:0];
   endfunction

   // Value / 100 for a full byte
   function automatic logic [1:0] hundreds_of(input logic [7:0] v);
      logic [15:0] p;
      p = {8'd0, v} * 16'd41;
      return p[13:12];
   endfunction

   function automatic logic [3:0] clamp_code(input logic [7:0] v);
      return (v > 8'(BLANK_CODE)) ? BLANK_CODE : v[3:0];
   endfunction

   logic [7:0]       rx_buffer_ff [DEPTH];
   logic [CNT_W-1:0] rx_count_ff;
   logic [CNT_W-1:0] rx_count_in;
   logic             accept;
   logic             room;
   logic [7:0]       rem100;
   logic [7:0]       b1;
   logic [7:0]       b2;
   op_type           op;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign room     = rx_count_ff <= LAST_CNT;
   assign b1       = rx_buffer_ff[1];
   assign b2       = rx_buffer_ff[2];
   assign rem100   = b1 - ({6'd0, hundreds_of(b1)} * 8'd100);

   // Classify the event and decode the message on a stop
   always_comb begin
      op        = '0;
      op.kind   = KIND_NOP;
      op.codes  = '0;
      rx_count_in = rx_count_ff;
      unique case (in_command)
         CMD_BYTE: begin
            op.kind = KIND_BYTE;
            if (room) begin
               rx_count_in = rx_count_ff + CNT_W'(1);
               op.ack      = rx_count_ff < LAST_CNT;
            end
         end
         CMD_STOP: begin
            op.kind     = KIND_STOP;
            rx_count_in = '0;
            unique case (rx_buffer_ff[0])
               8'd1: begin
                  op.update = 1'b1;
                  if (rx_buffer_ff[5][7]) begin
                     op.codes[0] = clamp_code(rx_buffer_ff[1]);
                     op.codes[1] = clamp_code(rx_buffer_ff[2]);
                     op.codes[2] = clamp_code(rx_buffer_ff[3]);
                     op.codes[3] = clamp_code(rx_buffer_ff[4]);
                  end else begin
                     op.codes = {4{BLANK_CODE}};
                  end
               end
               8'd2: begin
                  op.update = 1'b1;
                  if (b1 <= 8'd99) begin
                     op.codes[0] = tens_of(b1);
                     op.codes[1] = ones_of(b1);
                  end else begin
                     op.codes[0] = BLANK_CODE;
                     op.codes[1] = BLANK_CODE;
                  end
                  if (b2 <= 8'd99) begin
                     op.codes[2] = tens_of(b2);
                     op.codes[3] = ones_of(b2);
                  end else begin
                     op.codes[2] = BLANK_CODE;
                     op.codes[3] = BLANK_CODE;
                  end
               end
               8'd3: begin
                  op.update   = 1'b1;
                  op.codes[0] = ZERO_CODE;
                  op.codes[1] = {2'd0, hundreds_of(b1)};
                  op.codes[2] = tens_of(rem100);
                  op.codes[3] = ones_of(rem100);
               end
               default: op.update = 1'b0;
            endcase
         end
         CMD_TICK: op.kind = KIND_TICK;
         default:  op.kind = KIND_NOP;
      endcase
   end

   assign push    = accept;
   assign push_op = op;

   // Receive count
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff <= '0;
      end else if (accept) begin
         rx_count_ff <= rx_count_in;
      end
   end

   // Receive buffer storage
   always_ff @(posedge clock) begin
      if (accept && in_command == CMD_BYTE && room) begin
         rx_buffer_ff[rx_count_ff[IDX_W-1:0]] <= in_rx_byte;
      end
   end

endmodule

// File: sv/i2cssd_queue.sv
// Two-entry queue between the front end and the display back end.
`timescale 1ns / 1ps
module i2cssd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cssd_pkg::op_type  push_op,
   output logic                full,
   output logic                not_empty,
   input  logic                pop,
   output i2cssd_pkg::op_type  head_op
);
   import i2cssd_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_pop    = pop && not_empty;
   assign head_op   = slot_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: sv/i2cssd_back.sv
// Back end: digit codes, scan sequencer, colon blink, start-up test, result register.
`timescale 1ns / 1ps
module i2cssd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [i2cssd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   input  logic                op_valid,
   input  i2cssd_pkg::op_type  op,
   output logic                op_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_ack,
   output logic [7:0]          out_segments,
   output logic [4:0]          out_digit_select,
   output logic                out_colon_on
);
   import i2cssd_pkg::*;

   localparam logic [2:0] COLON_PHASE = 3'd4;

   // Configuration registers
   logic       blink_en_ff;
   logic [7:0] blink_frames_ff;
   logic [8:0] startup_ticks_ff;

   // Display state
   codes_type  codes_ff, codes_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] frame_ff, frame_in;
   logic       colon_ff, colon_in;
   logic [8:0] start_cnt_ff, start_cnt_in;
   logic       start_active_ff, start_active_in;
   logic       seen_ff, seen_in;
   logic [7:0] latch_ff, latch_in;

   // Result register
   logic       rsp_valid_ff;
   logic       rsp_ack_ff;
   logic [7:0] rsp_seg_ff;
   logic [4:0] rsp_sel_ff;
   logic       rsp_colon_ff;
   logic [4:0] sel_in;

   logic       step;
   logic [8:0] cnt_next;
   logic [7:0] frame_next;

   assign op_pop     = op_valid && (!rsp_valid_ff || out_ready);
   assign step       = op_pop;
   assign cnt_next   = start_cnt_ff + 9'd1;
   assign frame_next = frame_ff + 8'd1;

   // Next display state for the operation at the queue head
   always_comb begin
      codes_in        = codes_ff;
      phase_in        = phase_ff;
      frame_in        = frame_ff;
      colon_in        = colon_ff;
      start_cnt_in    = start_cnt_ff;
      start_active_in = start_active_ff;
      seen_in         = seen_ff;
      latch_in        = latch_ff;
      sel_in          = '0;
      if (op.kind == KIND_STOP && op.update) begin
         codes_in = op.codes;
         seen_in  = 1'b1;
      end
      if (op.kind == KIND_TICK) begin
         // start-up test timeout
         if (start_active_ff) begin
            start_cnt_in = cnt_next;
            if (cnt_next >= startup_ticks_ff) begin
               if (!seen_ff) begin
                  codes_in = {4{ZERO_CODE}};
               end
               start_active_in = 1'b0;
               start_cnt_in    = '0;
            end
         end
         // scan one line
         if (phase_ff < COLON_PHASE) begin
            latch_in = seg_pattern(codes_in[phase_ff[1:0]]);
            sel_in   = 5'd1 << phase_ff;
            phase_in = phase_ff + 3'd1;
         end else begin
            frame_in = frame_next;
            if (blink_en_ff) begin
               if (frame_next > blink_frames_ff) begin
                  colon_in = !colon_ff;
                  frame_in = '0;
               end
            end else begin
               colon_in = 1'b0;
            end
            sel_in   = 5'b10000;
            phase_in = '0;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_en_ff      <= 1'b0;
         blink_frames_ff  <= BLINK_FRAMES_RESET;
         startup_ticks_ff <= STARTUP_TICKS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_COLON_BLINK_EN: blink_en_ff      <= csr_wdata[0];
            CSR_BLINK_FRAMES:   blink_frames_ff  <= csr_wdata[7:0];
            CSR_STARTUP_TICKS:  startup_ticks_ff <= csr_wdata[8:0];
            default:            ;
         endcase
      end
   end

   // Display state update
   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff        <= {4{EIGHT_CODE}};
         phase_ff        <= '0;
         frame_ff        <= '0;
         colon_ff        <= 1'b0;
         start_cnt_ff    <= '0;
         start_active_ff <= 1'b1;
         seen_ff         <= 1'b0;
         latch_ff        <= '0;
      end else if (step) begin
         codes_ff        <= codes_in;
         phase_ff        <= phase_in;
         frame_ff        <= frame_in;
         colon_ff        <= colon_in;
         start_cnt_ff    <= start_cnt_in;
         start_active_ff <= start_active_in;
         seen_ff         <= seen_in;
         latch_ff        <= latch_in;
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ack_ff   <= (op.kind == KIND_BYTE) && op.ack;
         rsp_seg_ff   <= latch_in;
         rsp_sel_ff   <= sel_in;
         rsp_colon_ff <= colon_in;
      end
   end

   assign out_valid        = rsp_valid_ff;
   assign out_ack          = rsp_ack_ff;
   assign out_segments     = rsp_seg_ff;
   assign out_digit_select = rsp_sel_ff;
   assign out_colon_on     = rsp_colon_ff;

endmodule

// File: sv/i2c_seven_segment_display_controller_unit.sv
// Top level: four-digit seven-segment display controller behind a slave event stream.
`timescale 1ns / 1ps
// Takes one event per transfer (write byte, stop, scan tick) and returns one result per event,
// in order. A new event can be accepted every cycle while the two-entry queue is not full. The
// front end classifies the event combinationally and writes it into the queue; the back end
// pops it, applies it to the display state and loads the result register, one event per cycle,
// so sustained throughput is one event per clock whenever rsp_ready is high. Write bytes fill
// a receive buffer of LAST_RX_INDEX+1 bytes and are acknowledged only while a slot stays free
// after them; a stop decodes the buffer into the four digit codes, as byte 0 selects. Each
// tick drives the next of five scan lines (four digits, then the colon). Configuration writes
// take effect at once and are meant to be issued only while no events are in flight.
module i2c_seven_segment_display_controller_unit #(
   parameter int unsigned LAST_RX_INDEX = i2cssd_pkg::LAST_RX_INDEX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic [7:0]                            req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_ack,
   output logic [7:0]                            rsp_segments,
   output logic [4:0]                            rsp_digit_select,
   output logic                                  rsp_colon_on,
   input  logic                                  csr_write_en,
   input  logic [1:0]                            csr_index,
   input  logic [i2cssd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import i2cssd_pkg::*;

   logic   push;
   op_type push_op;
   logic   queue_full;
   logic   queue_not_empty;
   logic   pop;
   op_type head_op;

   i2cssd_front #(
      .LAST_RX_INDEX(LAST_RX_INDEX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_command (req_command),
      .in_rx_byte (req_rx_byte),
      .push       (push),
      .push_op    (push_op),
      .queue_full (queue_full)
   );

   i2cssd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .head_op   (head_op)
   );

   i2cssd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .op_valid         (queue_not_empty),
      .op               (head_op),
      .op_pop           (pop),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_ack          (rsp_ack),
      .out_segments     (rsp_segments),
      .out_digit_select (rsp_digit_select),
      .out_colon_on     (rsp_colon_on)
   );

endmodule
